// ----- hw/rtl/sre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_pkg
// Shared widths, constants and types of the sparse Rips edge weight block.
// ----------------------------------------------------------------------------
package sre_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = 17;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 32;
    localparam int SUM_W      = 41;
    localparam int INDEX_W    = 16;
    localparam int DEATH_W    = 24;
    localparam int SHRINK_W   = 17;
    localparam int ROOT_W     = 21;
    localparam int RAD_W      = 42;
    localparam int REM_W      = 24;
    localparam int PROD_W     = 41;
    localparam int FRAC_W     = 16;
    localparam int D16_W      = ROOT_W + FRAC_W;
    localparam int ALPHA_W    = D16_W + 1;
    localparam int WEIGHT_W   = 22;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [SHRINK_W-1:0] SHRINK_ONE   = 17'd65536;
    localparam logic [SHRINK_W-1:0] SHRINK_RESET = 17'd58982;

    // Register index taken from the word address.
    localparam logic REG_SHRINK = 1'b0;

    typedef struct packed {
        logic [SUM_W-1:0]   square_sum;
        logic [INDEX_W-1:0] index_a;
        logic [INDEX_W-1:0] index_b;
        logic [DEATH_W-1:0] death_a;
        logic [DEATH_W-1:0] death_b;
    } pair_t;

    typedef struct packed {
        logic  valid;
        pair_t pair;
    } pair_msg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROOT,
        B_MUL,
        B_ALPHA,
        B_DECIDE
    } back_state_t;

endpackage

// ----- hw/rtl/sre_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_front
// Accepts coordinate items, squares the differences and accumulates them;
// a finished pair is pushed into the queue.
// ----------------------------------------------------------------------------
module sre_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [sre_pkg::COORD_W-1:0] coord_a,
    input  logic signed [sre_pkg::COORD_W-1:0] coord_b,
    input  logic [sre_pkg::INDEX_W-1:0]    index_a,
    input  logic [sre_pkg::INDEX_W-1:0]    index_b,
    input  logic [sre_pkg::DEATH_W-1:0]    death_a,
    input  logic [sre_pkg::DEATH_W-1:0]    death_b,
    input  logic                           last,
    input  logic                           q_full,
    output sre_pkg::pair_msg_t             push
);

    logic                         s1_valid_reg;
    logic                         s1_last_reg;
    logic [sre_pkg::SQ_W-1:0]     sq_reg;
    logic [sre_pkg::INDEX_W-1:0]  index_a_reg;
    logic [sre_pkg::INDEX_W-1:0]  index_b_reg;
    logic [sre_pkg::DEATH_W-1:0]  death_a_reg;
    logic [sre_pkg::DEATH_W-1:0]  death_b_reg;
    logic [sre_pkg::SUM_W-1:0]    sum_reg;
    logic [sre_pkg::SUM_W-1:0]    sum_next;

    logic signed [sre_pkg::DIFF_W-1:0] diff;
    logic [sre_pkg::DIFF_W-1:0]        mag_wide;
    logic [sre_pkg::MAG_W-1:0]         mag;
    logic                              accept;
    logic                              advance;
    logic [sre_pkg::SUM_W:0]           sum_wide;
    logic [sre_pkg::SUM_W-1:0]         sum_sat;

    assign diff     = sre_pkg::DIFF_W'(coord_a) - sre_pkg::DIFF_W'(coord_b);
    assign mag_wide = diff[sre_pkg::DIFF_W-1] ? sre_pkg::DIFF_W'(-diff) : diff;
    // The magnitude never exceeds 65535, so the sign bit is always clear.
    assign mag      = mag_wide[sre_pkg::MAG_W-1:0];

    // The stage holds only while a finished pair waits for queue space.
    assign advance  = s1_valid_reg && !(s1_last_reg && q_full);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign sum_wide = {1'b0, sum_reg} + {{(sre_pkg::SUM_W + 1 - sre_pkg::SQ_W){1'b0}}, sq_reg};
    assign sum_sat  = sum_wide[sre_pkg::SUM_W] ? {sre_pkg::SUM_W{1'b1}}
                                               : sum_wide[sre_pkg::SUM_W-1:0];

    always_comb
    begin
        sum_next = sum_reg;
        if (advance)
        begin
            sum_next = s1_last_reg ? '0 : sum_sat;
        end
    end

    always_comb
    begin
        push.valid           = advance && s1_last_reg;
        push.pair.square_sum = sum_sat;
        push.pair.index_a    = index_a_reg;
        push.pair.index_b    = index_b_reg;
        push.pair.death_a    = death_a_reg;
        push.pair.death_b    = death_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !advance);
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg      <= mag * mag;
            s1_last_reg <= last;
            index_a_reg <= index_a;
            index_b_reg <= index_b;
            death_a_reg <= death_a;
            death_b_reg <= death_b;
        end
    end

endmodule

// ----- hw/rtl/sre_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_queue
// Two-entry queue of finished pairs between the front and the back.
// ----------------------------------------------------------------------------
module sre_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  sre_pkg::pair_msg_t push,
    output logic               full,
    input  logic               pop,
    output sre_pkg::pair_msg_t head
);

    sre_pkg::pair_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.pair  = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.pair;
        end
    end

endmodule

// ----- hw/rtl/sre_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_back
// Takes a pair from the queue, forms the integer square root one bit a
// cycle, applies the shrink factor and decides on the edge weight.
// ----------------------------------------------------------------------------
module sre_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sre_pkg::SHRINK_W-1:0]  shrink_factor,
    input  sre_pkg::pair_msg_t            head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sre_pkg::INDEX_W-1:0]   endpoint_a,
    output logic [sre_pkg::INDEX_W-1:0]   endpoint_b,
    output logic [sre_pkg::WEIGHT_W-1:0]  edge_weight
);

    sre_pkg::back_state_t state_reg;
    sre_pkg::back_state_t state_next;

    logic [sre_pkg::RAD_W-1:0]    rad_reg;
    logic [sre_pkg::REM_W-1:0]    rem_reg;
    logic [sre_pkg::ROOT_W-1:0]   root_reg;
    logic [sre_pkg::STEP_W-1:0]   step_reg;
    logic [sre_pkg::INDEX_W-1:0]  idx_a_reg;
    logic [sre_pkg::INDEX_W-1:0]  idx_b_reg;
    logic [sre_pkg::DEATH_W-1:0]  tp_reg;
    logic [sre_pkg::DEATH_W-1:0]  tq_reg;
    logic [sre_pkg::PROD_W-1:0]   stp_reg;
    logic [sre_pkg::PROD_W-1:0]   stq_reg;
    logic                         plain_reg;
    logic [sre_pkg::ALPHA_W-1:0]  alpha_reg;
    logic                         out_valid_reg;
    logic [sre_pkg::INDEX_W-1:0]  endpoint_a_reg;
    logic [sre_pkg::INDEX_W-1:0]  endpoint_b_reg;
    logic [sre_pkg::WEIGHT_W-1:0] edge_weight_reg;

    logic                         root_last;
    logic                         slot_free;
    logic                         out_load;
    logic [sre_pkg::REM_W-1:0]    rem_shift;
    logic [sre_pkg::REM_W-1:0]    trial;
    logic                         take;
    logic [sre_pkg::SHRINK_W-1:0] shrink_eff;
    logic [sre_pkg::D16_W-1:0]    d16;
    logic                         swap;
    logic                         relax_ok;
    logic                         emit;
    logic [sre_pkg::WEIGHT_W-1:0] weight;

    assign root_last = (step_reg == sre_pkg::STEP_W'(sre_pkg::ROOT_STEPS - 1));
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sre_pkg::B_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = sre_pkg::B_ROOT;
                end
            end
            sre_pkg::B_ROOT:
            begin
                if (root_last)
                begin
                    state_next = sre_pkg::B_MUL;
                end
            end
            sre_pkg::B_MUL:    state_next = sre_pkg::B_ALPHA;
            sre_pkg::B_ALPHA:  state_next = sre_pkg::B_DECIDE;
            sre_pkg::B_DECIDE:
            begin
                if (slot_free)
                begin
                    state_next = sre_pkg::B_IDLE;
                end
            end
            default:           state_next = sre_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            sre_pkg::B_IDLE:   pop      = head.valid;
            sre_pkg::B_DECIDE: out_load = slot_free;
            default:
            begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // Restoring square root: two radicand bits enter the remainder per step.
    assign rem_shift  = {rem_reg[sre_pkg::REM_W-3:0], rad_reg[sre_pkg::RAD_W-1 -: 2]};
    assign trial      = {1'b0, root_reg, 2'b01};
    assign take       = (rem_shift >= trial);

    assign shrink_eff = (shrink_factor > sre_pkg::SHRINK_ONE) ? sre_pkg::SHRINK_ONE
                                                              : shrink_factor;
    assign d16        = {root_reg, {sre_pkg::FRAC_W{1'b0}}};
    assign swap       = (head.pair.death_b < head.pair.death_a);

    assign relax_ok = (sre_pkg::PROD_W'(alpha_reg) >= stp_reg)
                   && (sre_pkg::PROD_W'(alpha_reg) <=
                       sre_pkg::PROD_W'({tp_reg, {sre_pkg::FRAC_W{1'b0}}}))
                   && (sre_pkg::PROD_W'(alpha_reg) <= stq_reg);
    assign emit     = plain_reg || relax_ok;
    assign weight   = plain_reg ? sre_pkg::WEIGHT_W'(root_reg)
                                : alpha_reg[sre_pkg::ALPHA_W-1:sre_pkg::FRAC_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sre_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= (out_valid_reg && !out_ready) || (out_load && emit);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sre_pkg::B_IDLE:
            begin
                if (head.valid)
                begin
                    rad_reg   <= {1'b0, head.pair.square_sum};
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    step_reg  <= '0;
                    idx_a_reg <= head.pair.index_a;
                    idx_b_reg <= head.pair.index_b;
                    tp_reg    <= swap ? head.pair.death_b : head.pair.death_a;
                    tq_reg    <= swap ? head.pair.death_a : head.pair.death_b;
                end
            end
            sre_pkg::B_ROOT:
            begin
                rad_reg  <= {rad_reg[sre_pkg::RAD_W-3:0], 2'b00};
                rem_reg  <= take ? (rem_shift - trial) : rem_shift;
                root_reg <= {root_reg[sre_pkg::ROOT_W-2:0], take};
                step_reg <= step_reg + sre_pkg::STEP_W'(1);
            end
            sre_pkg::B_MUL:
            begin
                stp_reg <= shrink_eff * tp_reg;
                stq_reg <= shrink_eff * tq_reg;
            end
            sre_pkg::B_ALPHA:
            begin
                plain_reg <= (sre_pkg::PROD_W'(d16) < stp_reg);
                // Only used when d16 >= s*tp, so the low bits of s*tp suffice.
                alpha_reg <= {d16, 1'b0} - stp_reg[sre_pkg::ALPHA_W-1:0];
            end
            default:
            begin
                rad_reg <= rad_reg;
            end
        endcase

        if (out_load && emit)
        begin
            endpoint_a_reg  <= idx_a_reg;
            endpoint_b_reg  <= idx_b_reg;
            edge_weight_reg <= weight;
        end
    end

    assign out_valid   = out_valid_reg;
    assign endpoint_a  = endpoint_a_reg;
    assign endpoint_b  = endpoint_b_reg;
    assign edge_weight = edge_weight_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sre_pkg::B_ROOT)
        |-> (rem_reg <= sre_pkg::REM_W'({root_reg, 1'b0})))
        else $error("square root remainder exceeds twice the partial root");

    a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sre_pkg::B_ROOT && !root_last) |=> (state_reg == sre_pkg::B_ROOT))
        else $error("square root left before all steps were done");

    a_death_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sre_pkg::B_IDLE) |-> (tp_reg <= tq_reg))
        else $error("death times not ordered");

    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !emit) |=> !out_valid_reg)
        else $error("rejected edge produced an output item");

endmodule

// ----- hw/rtl/sparse_rips_edge_weight.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_rips_edge_weight
// Edge weight of a sparse Rips filtration from two points and death times.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one item per coordinate pair of two
// points, last set on the final coordinate. Index and death time fields are
// read only on the last item. The front takes one item per cycle unless a
// finished pair waits for queue space, squaring the difference in one stage
// and accumulating it in the next. A finished pair enters a two-entry queue.
// The back pops a pair in B_IDLE, computes the integer square root one bit
// per cycle in B_ROOT, multiplies in B_MUL, subtracts in B_ALPHA and decides
// in B_DECIDE. It works on one pair at a time, so throughput is set by the
// front or the back, whichever is slower; a pair passes the front stage, the
// queue and the back states before out_valid rises.
// Output channel (out_valid/out_ready): zero or one item per pair, held in
// an output register. While the receiver stalls, the back holds its decided
// pair, the queue fills, and then in_ready drops on the next last item.
// The APB port holds shrink_factor at address 0. The user must see that it
// is written only while the block is idle; the block does not enforce this.
// Reset clears the sum, the queue and out_valid and sets shrink_factor to 58982.
// ----------------------------------------------------------------------------
module sparse_rips_edge_weight (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sre_pkg::ADDR_W-1:0]         paddr,
    input  logic [sre_pkg::DATA_W-1:0]         pwdata,
    output logic [sre_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [sre_pkg::COORD_W-1:0] coord_a,
    input  logic signed [sre_pkg::COORD_W-1:0] coord_b,
    input  logic [sre_pkg::INDEX_W-1:0]        index_a,
    input  logic [sre_pkg::INDEX_W-1:0]        index_b,
    input  logic [sre_pkg::DEATH_W-1:0]        death_a,
    input  logic [sre_pkg::DEATH_W-1:0]        death_b,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sre_pkg::INDEX_W-1:0]        endpoint_a,
    output logic [sre_pkg::INDEX_W-1:0]        endpoint_b,
    output logic [sre_pkg::WEIGHT_W-1:0]       edge_weight
);

    logic [sre_pkg::SHRINK_W-1:0] shrink_reg;
    logic                         reg_sel;
    logic                         q_full;
    logic                         q_pop;
    sre_pkg::pair_msg_t           push;
    sre_pkg::pair_msg_t           head;

    assign pready  = 1'b1;
    assign reg_sel = paddr[sre_pkg::ADDR_W-1];
    assign prdata  = (reg_sel == sre_pkg::REG_SHRINK)
                   ? sre_pkg::DATA_W'(shrink_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shrink_reg <= sre_pkg::SHRINK_RESET;
        end
        else if (psel && penable && pwrite && pready && (reg_sel == sre_pkg::REG_SHRINK))
        begin
            shrink_reg <= pwdata[sre_pkg::SHRINK_W-1:0];
        end
    end

    sre_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .coord_a  (coord_a),
        .coord_b  (coord_b),
        .index_a  (index_a),
        .index_b  (index_b),
        .death_a  (death_a),
        .death_b  (death_b),
        .last     (last),
        .q_full   (q_full),
        .push     (push)
    );

    sre_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (q_pop),
        .head  (head)
    );

    sre_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .shrink_factor (shrink_reg),
        .head          (head),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .endpoint_a    (endpoint_a),
        .endpoint_b    (endpoint_b),
        .edge_weight   (edge_weight)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse Rips edge weight block.
// ----------------------------------------------------------------------------
// A queue of coordinate items feeds a valid/ready driver. Each accepted item
// goes through a local predictor that keeps its own running square sum and
// shrink factor. Finished pairs leave an expected edge, or nothing, in a
// scoreboard queue. A monitor under random back-pressure checks every edge
// that leaves the block against that queue. The run steps through several
// shrink factors written over APB while the block is idle: zero, values
// below one, one, values above one, and a masked all-ones write. One phase
// also carries a pair long enough to saturate the square sum.
// ----------------------------------------------------------------------------
module tb;

    localparam int          NOMINAL_DIMS    = 8;
    localparam int          PHASES          = 8;
    localparam int          ITEMS_PER_PHASE = 30;
    localparam int          LONG_PHASE      = 1;
    localparam int          LONG_PAIR_ITEMS = 530;
    localparam int          DRAIN_CYCLES    = 100;
    localparam int          QUIET_LIMIT     = 2000;
    localparam logic [63:0] SQ_SUM_MAX      = (64'd1 << sre_pkg::SUM_W) - 1;
    localparam logic [63:0] WEIGHT_LIMIT    = (64'd1 << sre_pkg::WEIGHT_W) - 1;
    localparam logic [sre_pkg::ADDR_W-1:0] SHRINK_ADDR = {sre_pkg::REG_SHRINK, 2'b00};

    typedef struct {
        logic signed [sre_pkg::COORD_W-1:0] coord_a;
        logic signed [sre_pkg::COORD_W-1:0] coord_b;
        logic [sre_pkg::INDEX_W-1:0]        index_a;
        logic [sre_pkg::INDEX_W-1:0]        index_b;
        logic [sre_pkg::DEATH_W-1:0]        death_a;
        logic [sre_pkg::DEATH_W-1:0]        death_b;
        logic                               last;
    } coord_item_t;

    typedef struct {
        logic [sre_pkg::INDEX_W-1:0]  endpoint_a;
        logic [sre_pkg::INDEX_W-1:0]  endpoint_b;
        logic [sre_pkg::WEIGHT_W-1:0] weight;
    } graph_edge_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [sre_pkg::ADDR_W-1:0]         paddr = '0;
    logic [sre_pkg::DATA_W-1:0]         pwdata = '0;
    logic [sre_pkg::DATA_W-1:0]         prdata;
    logic                               pready;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic signed [sre_pkg::COORD_W-1:0] coord_a = '0;
    logic signed [sre_pkg::COORD_W-1:0] coord_b = '0;
    logic [sre_pkg::INDEX_W-1:0]        index_a = '0;
    logic [sre_pkg::INDEX_W-1:0]        index_b = '0;
    logic [sre_pkg::DEATH_W-1:0]        death_a = '0;
    logic [sre_pkg::DEATH_W-1:0]        death_b = '0;
    logic                               last = 1'b0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [sre_pkg::INDEX_W-1:0]        endpoint_a;
    logic [sre_pkg::INDEX_W-1:0]        endpoint_b;
    logic [sre_pkg::WEIGHT_W-1:0]       edge_weight;

    coord_item_t                  pending_items[$];
    graph_edge_t                  expected_edges[$];
    coord_item_t                  cur;
    logic                         holding = 1'b0;
    logic [sre_pkg::SUM_W-1:0]    pair_sum = '0;
    logic [sre_pkg::SHRINK_W-1:0] shrink_now = sre_pkg::SHRINK_RESET;
    int                           in_gap_left = 0;
    int                           out_stall_left = 0;
    int                           in_gap_pct = 20;
    int                           out_gap_pct = 10;
    int                           mismatch_count = 0;
    int                           quiet_cycles = 0;
    logic [sre_pkg::DATA_W-1:0]   shrink_plan [PHASES] = '{
        32'd0, 32'd65536, 32'd131071, 32'd32768,
        32'd0, 32'd65535, 32'hFFFF_FFFF, 32'd58982
    };

    sparse_rips_edge_weight dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .coord_a     (coord_a),
        .coord_b     (coord_b),
        .index_a     (index_a),
        .index_b     (index_b),
        .death_a     (death_a),
        .death_b     (death_b),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .endpoint_a  (endpoint_a),
        .endpoint_b  (endpoint_b),
        .edge_weight (edge_weight)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Adds one squared coordinate difference, saturating at the sum's width.
    function automatic logic [sre_pkg::SUM_W-1:0] add_square(
        input logic [sre_pkg::SUM_W-1:0]          sum,
        input logic signed [sre_pkg::COORD_W-1:0] a,
        input logic signed [sre_pkg::COORD_W-1:0] b);
        logic signed [sre_pkg::DIFF_W-1:0] diff;
        logic [63:0]                       mag;
        logic [63:0]                       total;
        diff = a - b;
        if (diff < 0)
            diff = -diff;
        mag = 64'(diff);
        total = 64'(sum) + mag * mag;
        if (total > SQ_SUM_MAX)
            total = SQ_SUM_MAX;
        return total[sre_pkg::SUM_W-1:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = sre_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // Decides plain, relaxed or dropped for a finished pair. All compares are
    // exact at the Q25.16 scale of the shrink products.
    function automatic bit weigh_pair(input logic [sre_pkg::SUM_W-1:0] sum,
                                      input coord_item_t it,
                                      input logic [sre_pkg::SHRINK_W-1:0] shrink,
                                      output graph_edge_t result);
        logic [63:0] s, tp, tq, d, stp, stq, d16, alpha, w;
        s = (shrink > sre_pkg::SHRINK_ONE) ? 64'(sre_pkg::SHRINK_ONE) : 64'(shrink);
        tp = 64'(it.death_a);
        tq = 64'(it.death_b);
        if (tq < tp)
        begin
            w = tp;
            tp = tq;
            tq = w;
        end
        d = root_floor(64'(sum));
        stp = s * tp;
        stq = s * tq;
        d16 = d << sre_pkg::FRAC_W;
        result.endpoint_a = it.index_a;
        result.endpoint_b = it.index_b;
        result.weight = '0;
        if (d16 < stp)
            w = d;
        else
        begin
            alpha = 2 * d16 - stp;
            if (alpha < stp || alpha > (tp << sre_pkg::FRAC_W) || alpha > stq)
                return 1'b0;
            w = alpha >> sre_pkg::FRAC_W;
        end
        if (w > WEIGHT_LIMIT)
            w = WEIGHT_LIMIT;
        result.weight = w[sre_pkg::WEIGHT_W-1:0];
        return 1'b1;
    endfunction

    task automatic absorb_item(input coord_item_t it);
        graph_edge_t e;
        pair_sum = add_square(pair_sum, it.coord_a, it.coord_b);
        if (it.last)
        begin
            if (weigh_pair(pair_sum, it, shrink_now, e))
                expected_edges = {expected_edges, e};
            pair_sum = '0;
        end
    endtask

    function automatic int draw_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(4) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic queue_item(input logic signed [sre_pkg::COORD_W-1:0] ca,
                              input logic signed [sre_pkg::COORD_W-1:0] cb,
                              input logic [sre_pkg::INDEX_W-1:0] ia,
                              input logic [sre_pkg::INDEX_W-1:0] ib,
                              input logic [sre_pkg::DEATH_W-1:0] da,
                              input logic [sre_pkg::DEATH_W-1:0] db,
                              input logic lst);
        coord_item_t it;
        it.coord_a = ca;
        it.coord_b = cb;
        it.index_a = ia;
        it.index_b = ib;
        it.death_a = da;
        it.death_b = db;
        it.last = lst;
        pending_items = {pending_items, it};
    endtask

    // Most pairs get death times scaled from their own distance so that the
    // plain, relaxed and dropped outcomes all come up often.
    task automatic queue_pair(input int dims);
        coord_item_t               it;
        logic [sre_pkg::SUM_W-1:0] sum;
        logic [63:0]               d, tp, tq;
        int                        mode;
        sum = '0;
        mode = $urandom_range(9);
        for (int k = 0; k < dims; k++)
        begin
            if (mode < 2)
            begin
                it.coord_a = sre_pkg::COORD_W'($urandom);
                it.coord_b = sre_pkg::COORD_W'($urandom);
            end
            else
            begin
                it.coord_a = sre_pkg::COORD_W'(int'($urandom_range(2047)) - 1024);
                it.coord_b = sre_pkg::COORD_W'(int'($urandom_range(2047)) - 1024);
            end
            it.index_a = sre_pkg::INDEX_W'($urandom);
            it.index_b = sre_pkg::INDEX_W'($urandom);
            it.death_a = sre_pkg::DEATH_W'($urandom);
            it.death_b = sre_pkg::DEATH_W'($urandom);
            it.last = (k == dims - 1);
            sum = add_square(sum, it.coord_a, it.coord_b);
            if (it.last && mode >= 3)
            begin
                d = root_floor(64'(sum));
                tp = d * $urandom_range(48, 100) / 64 + $urandom_range(3);
                if ($urandom_range(3) == 0)
                    tq = tp;
                else
                    tq = tp * $urandom_range(64, 128) / 64 + $urandom_range(7);
                if ($urandom_range(1))
                begin
                    it.death_a = tp[sre_pkg::DEATH_W-1:0];
                    it.death_b = tq[sre_pkg::DEATH_W-1:0];
                end
                else
                begin
                    it.death_a = tq[sre_pkg::DEATH_W-1:0];
                    it.death_b = tp[sre_pkg::DEATH_W-1:0];
                end
            end
            pending_items = {pending_items, it};
        end
    endtask

    task automatic write_shrink(input logic [sre_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SHRINK_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shrink_now = value[sre_pkg::SHRINK_W-1:0];
    endtask

    // Waits until every item is in and every edge is out, then gives the
    // back stage time to finish pairs that produce no edge.
    task automatic drain();
        while (pending_items.size() != 0 || holding || expected_edges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                absorb_item(cur);
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (in_gap_left != 0)
                    in_gap_left--;
                else if (pending_items.size() != 0)
                begin
                    cur = pending_items.pop_front();
                    holding = 1'b1;
                    in_gap_left = draw_gap(in_gap_pct);
                end
            end
            in_valid <= holding;
            coord_a <= cur.coord_a;
            coord_b <= cur.coord_b;
            index_a <= cur.index_a;
            index_b <= cur.index_b;
            death_a <= cur.death_a;
            death_b <= cur.death_b;
            last <= cur.last;
        end
    end

    always @(posedge clk)
    begin
        graph_edge_t got;
        graph_edge_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.endpoint_a = endpoint_a;
                got.endpoint_b = endpoint_b;
                got.weight = edge_weight;
                if (expected_edges.size() == 0)
                    log_mismatch($sformatf("unexpected edge %0d-%0d weight %0d",
                                           got.endpoint_a, got.endpoint_b, got.weight));
                else
                begin
                    want = expected_edges.pop_front();
                    if (got.endpoint_a !== want.endpoint_a)
                        log_mismatch($sformatf("endpoint_a expected %0d, got %0d",
                                               want.endpoint_a, got.endpoint_a));
                    if (got.endpoint_b !== want.endpoint_b)
                        log_mismatch($sformatf("endpoint_b expected %0d, got %0d",
                                               want.endpoint_b, got.endpoint_b));
                    if (got.weight !== want.weight)
                        log_mismatch($sformatf("edge_weight expected %0d, got %0d",
                                               want.weight, got.weight));
                end
            end
            if (out_stall_left != 0)
            begin
                out_stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall_left = draw_gap(out_gap_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int queued;
        int dims;
        shrink_plan[4] = $urandom_range(65536);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs under the reset shrink factor. For a distance of 256 and
        // s near 0.9 the relaxed band for tp is about 270 to 284.
        queue_item(16'sd32767, -16'sd32768, 16'd0, 16'hFFFF, 24'hFFFFFF, 24'd0, 1'b1);
        queue_item(-16'sd32768, 16'sd32767, 16'hFFFF, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        queue_item(16'sd0, 16'sd0, 16'd1, 16'd2, 24'd0, 24'd0, 1'b1);
        queue_item(16'sd5, 16'sd5, 16'd3, 16'd4, 24'd100, 24'd200, 1'b1);
        queue_item(16'sd256, 16'sd0, 16'hAAAA, 16'h5555, 24'hAAAAAA, 24'h555555, 1'b0);
        queue_item(-16'sd256, 16'sd0, 16'h5555, 16'hAAAA, 24'h555555, 24'hAAAAAA, 1'b0);
        queue_item(16'sd100, -16'sd100, 16'd7, 16'd8, 24'd9, 24'd9, 1'b0);
        queue_item(16'sd0, 16'sd512, 16'd10, 16'd11, 24'h001000, 24'h002000, 1'b1);
        queue_item(16'sd256, 16'sd0, 16'd20, 16'd21, 24'd280, 24'd400, 1'b1);
        queue_item(16'sd0, 16'sd256, 16'd22, 16'd23, 24'd400, 24'd280, 1'b1);
        queue_item(16'sd256, 16'sd0, 16'd24, 16'd25, 24'd100, 24'd5000, 1'b1);
        queue_item(16'sd256, 16'sd0, 16'd26, 16'd27, 24'd280, 24'd280, 1'b1);
        queue_item(16'sd256, 16'sd0, 16'd28, 16'd29, 24'd1000, 24'hFFFFFF, 1'b1);
        queue_item(-16'sd1, 16'sd1, 16'd30, 16'd31, 24'd3, 24'd2, 1'b0);
        queue_item(-16'sd32768, -16'sd32768, 16'd32, 16'd33, 24'd3, 24'd2, 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_shrink(shrink_plan[p]);
            case (p)
                2:
                begin
                    in_gap_pct = 0;
                    out_gap_pct = 0;
                end
                5:
                begin
                    in_gap_pct = 10;
                    out_gap_pct = 60;
                end
                default:
                begin
                    in_gap_pct = 30;
                    out_gap_pct = 15;
                end
            endcase
            queued = 0;
            while (queued < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(9) == 0)
                    dims = $urandom_range(NOMINAL_DIMS + 1, 2 * NOMINAL_DIMS);
                else
                    dims = $urandom_range(1, NOMINAL_DIMS);
                queue_pair(dims);
                queued += dims;
            end
            // Enough maximal differences to run the square sum into saturation.
            if (p == LONG_PHASE)
            begin
                for (int k = 0; k < LONG_PAIR_ITEMS - 1; k++)
                    queue_item(16'sd32767, -16'sd32768, 16'd0, 16'd0, 24'd0, 24'd0, 1'b0);
                queue_item(-16'sd32768, 16'sd32767, sre_pkg::INDEX_W'($urandom),
                           sre_pkg::INDEX_W'($urandom), 24'hFFFFFF,
                           sre_pkg::DEATH_W'($urandom), 1'b1);
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sre_pkg.sv
hw/rtl/sre_front.sv
hw/rtl/sre_queue.sv
hw/rtl/sre_back.sv
hw/rtl/sparse_rips_edge_weight.sv
tb/tb.sv
